// ===== src/spsc_pkg.sv =====
package spsc_pkg;

  // Capacity register width and reset value
  localparam int unsigned CAP_W          = 11;
  localparam int unsigned CAP_RESET      = 5;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_MAX_DEPTH  = 1024;
  localparam int unsigned DEF_VALUE_BITS = 10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_POP_WAIT,
    ST_EMIT
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic load;      // capture accepted word
    logic push;      // push next number
    logic pop;       // drop top entry
    logic rd;        // fetch new top from store
    logic set_fail;  // raise sticky failure
    logic load_top;  // top <= store read data
    logic emit;      // load verdict, clear sequence state
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic failed;    // sticky failure flag
    logic hit;       // top of stack equals value
    logic no_room;   // push impossible or pointless
    logic deep;      // more than one entry on stack
    logic last;      // captured word ends sequence
    logic out_free;  // verdict register can take a word
  } sts_t;

endpackage

// ===== src/spsc_ram.sv =====
module spsc_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/spsc_datapath.sv =====
module spsc_datapath #(
  parameter int unsigned MAX_DEPTH  = 1024,
  parameter int unsigned VALUE_BITS = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [spsc_pkg::CAP_W-1:0]   cfg_wdata_i,
  input  logic [VALUE_BITS-1:0]        value_i,
  input  logic                         last_i,
  input  logic                         out_ready_i,
  input  spsc_pkg::cmd_t               cmd_i,
  output spsc_pkg::sts_t               sts_o,
  output logic                         out_valid_o,
  output logic                         out_bit_o
);
  import spsc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_DEPTH);
  localparam int unsigned LW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned NW = VALUE_BITS + 1;
  localparam int unsigned CW = (LW > CAP_W) ? LW : CAP_W;

  logic [CAP_W-1:0]      cap_q;
  logic [VALUE_BITS-1:0] val_q;
  logic                  last_q;
  logic [VALUE_BITS-1:0] top_q;
  logic [LW-1:0]         level_q, level_d;
  logic [NW-1:0]         next_q, next_d;
  logic                  failed_q, failed_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_bit_q;

  logic [CW-1:0]         cap_ext, eff_cap, level_ext;
  logic [LW-1:0]         level_m2;
  logic [VALUE_BITS-1:0] rdata;
  logic                  full, behind;

  // capacity clamped to the store depth
  assign cap_ext   = CW'(cap_q);
  assign eff_cap   = (cap_ext > CW'(MAX_DEPTH)) ? CW'(MAX_DEPTH) : cap_ext;
  assign level_ext = CW'(level_q);
  assign full      = (level_ext >= eff_cap);
  // value already pushed earlier and not on top: can never match
  assign behind    = ({1'b0, val_q} < next_q);
  assign level_m2  = level_q - LW'(2);

  assign sts_o.failed   = failed_q;
  assign sts_o.hit      = (level_q != '0) && (top_q == val_q);
  assign sts_o.no_room  = behind || full;
  assign sts_o.deep     = (level_q > LW'(1));
  assign sts_o.last     = last_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  spsc_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (level_q[AW-1:0]),
    .wdata_i (next_q[VALUE_BITS-1:0]),
    .re_i    (cmd_i.rd),
    .raddr_i (level_m2[AW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    level_d     = level_q;
    next_d      = next_q;
    failed_d    = failed_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.push) begin
      level_d = level_q + LW'(1);
      next_d  = next_q + NW'(1);
    end
    if (cmd_i.pop) begin
      level_d = level_q - LW'(1);
    end
    if (cmd_i.set_fail) begin
      failed_d = 1'b1;
    end
    if (cmd_i.emit) begin
      level_d     = '0;
      next_d      = NW'(1);
      failed_d    = 1'b0;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_W'(CAP_RESET);
      level_q     <= '0;
      next_q      <= NW'(1);
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      level_q     <= level_d;
      next_q      <= next_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q  <= value_i;
      last_q <= last_i;
    end
    if (cmd_i.push) begin
      top_q <= next_q[VALUE_BITS-1:0];
    end
    if (cmd_i.load_top) begin
      top_q <= rdata;
    end
    if (cmd_i.emit) begin
      out_bit_q <= !failed_q && (level_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_bit_o   = out_bit_q;

endmodule

// ===== src/spsc_ctrl.sv =====
module spsc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  spsc_pkg::sts_t sts_i,
  output spsc_pkg::cmd_t cmd_o
);
  import spsc_pkg::*;

  state_e state_q, state_d;
  state_e finish_st;

  assign finish_st = sts_i.last ? ST_EMIT : ST_IDLE;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        priority if (sts_i.failed) begin
          state_d = finish_st;
        end else if (sts_i.hit) begin
          state_d = sts_i.deep ? ST_POP_WAIT : finish_st;
        end else if (sts_i.no_room) begin
          state_d = finish_st;
        end else begin
          state_d = ST_STEP;
        end
      end
      ST_POP_WAIT: begin
        state_d = finish_st;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_STEP: begin
        priority if (sts_i.failed) begin
          cmd_o = '0;
        end else if (sts_i.hit) begin
          cmd_o.pop = 1'b1;
          cmd_o.rd  = sts_i.deep;
        end else if (sts_i.no_room) begin
          cmd_o.set_fail = 1'b1;
        end else begin
          cmd_o.push = 1'b1;
        end
      end
      ST_POP_WAIT: begin
        cmd_o.load_top = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/stack_pop_sequence_checker.sv =====
// Channel | Dir | Handshake            | Payload
// --------+-----+----------------------+---------------------------------------
// s_axis  | in  | s_axis_tvalid/tready | tdata: pop_value; tlast: last_in_seq
// m_axis  | out | m_axis_tvalid/tready | tdata: sequence_valid (bit 0)
// cfg     | in  | cfg_we_i             | cfg_wdata_i: stack_capacity
//
// Per word: accept, one push per number the value needs, then pop or fail;
// a pop that leaves any entry behind adds a registered store read of the new
// top, and a last word adds the verdict. Intake stays closed until it is done.
// Reset: sequence state clears at once; the stack store needs no clearing.
// Stalls: a waiting verdict never blocks intake; only a second verdict does.
module stack_pop_sequence_checker #(
  parameter int unsigned MAX_DEPTH  = spsc_pkg::DEF_MAX_DEPTH,
  parameter int unsigned VALUE_BITS = spsc_pkg::DEF_VALUE_BITS,
  localparam int unsigned DW        = ((VALUE_BITS + 7) / 8) * 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // stack capacity register
  input  logic                       cfg_we_i,
  input  logic [spsc_pkg::CAP_W-1:0] cfg_wdata_i,
  // value stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [DW-1:0]              s_axis_tdata,  // [VALUE_BITS-1:0] pop_value
  input  logic                       s_axis_tlast,  // last_in_sequence
  // verdict stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata   // [0] sequence_valid
);
  import spsc_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic out_bit;

  // FSM: accept, push loop, pop, verdict
  spsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // stack store, top register, counters, verdict register
  spsc_datapath #(
    .MAX_DEPTH  (MAX_DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .value_i     (s_axis_tdata[VALUE_BITS-1:0]),
    .last_i      (s_axis_tlast),
    .out_ready_i (m_axis_tready),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_bit_o   (out_bit)
  );

  assign m_axis_tdata = {7'b0, out_bit};

  // a word in flight keeps intake closed for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("intake open right after accept");

  // never push onto a full stack or past a match
  a_push_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> !sts.no_room && !sts.hit && !sts.failed)
    else $error("illegal push");

  // verdict loaded only into a free output register, and it shows next cycle
  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free ##1 m_axis_tvalid)
    else $error("verdict lost");

  // store read only on a pop that leaves entries behind
  a_read_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd |-> cmd.pop && sts.deep)
    else $error("stray store read");

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spsc_pkg::*;

  localparam int unsigned DEPTH  = DEF_MAX_DEPTH;
  localparam int unsigned VB     = DEF_VALUE_BITS;
  localparam int unsigned DW     = ((VB + 7) / 8) * 8;
  // Quiet cycles after the last verdict before touching the capacity register.
  localparam int unsigned SETTLE = 16;
  // The slowest legal run stays well under this limit, leaving a wide margin.
  localparam int unsigned CYCLE_LIMIT = 600000;

  // ---------------------------------------------------------------------------
  // DUT hookup. All inputs start at known values.
  // ---------------------------------------------------------------------------
  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic [CAP_W-1:0] cfg_wdata_i   = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [DW-1:0]    s_axis_tdata  = '0;  // [VB-1:0] pop_value, rest zero
  logic             s_axis_tlast  = 1'b0;  // last_in_sequence
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;  // [0] sequence_valid

  stack_pop_sequence_checker #(
    .MAX_DEPTH (DEPTH),
    .VALUE_BITS(VB)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shared bookkeeping
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [VB-1:0] value;
    logic          last;
  } pop_word_t;

  pop_word_t   word_q[$];       // words waiting for the driver
  bit          verdict_q[$];    // predicted sequence_valid, oldest first
  int unsigned words_queued  = 0;
  int unsigned words_acc     = 0;
  int unsigned verdicts_seen = 0;
  int unsigned passes_seen   = 0;
  int unsigned cap_writes    = 0;
  int unsigned err_cnt       = 0;
  int unsigned cyc_cnt       = 0;
  bit          idle_on       = 1'b1;  // random idling on both sides

  // ---------------------------------------------------------------------------
  // Stack image: tracks the block's sequence state and capacity.
  // ---------------------------------------------------------------------------
  logic [VB-1:0]    stack_img [DEPTH];
  int unsigned      depth_now  = 0;
  int unsigned      next_num   = 1;
  bit               seq_broken = 1'b0;
  logic [CAP_W-1:0] cap_now    = CAP_W'(CAP_RESET);

  // Push 1, 2, 3, ... until the top matches, then pop. A value below the
  // next number to push can never match, so it fails at once, as does a
  // push into a full stack. Once broken, words are skipped until tlast.
  function automatic void pop_and_judge(input logic [VB-1:0] v, input logic last);
    int unsigned room;
    bit          done;
    room = (cap_now > DEPTH) ? DEPTH : cap_now;  // capacity saturates at depth
    done = seq_broken;
    while (!done) begin
      if (depth_now > 0 && stack_img[depth_now-1] == v) begin
        depth_now--;
        done = 1'b1;
      end else if (v < next_num || depth_now >= room) begin
        seq_broken = 1'b1;
        done       = 1'b1;
      end else begin
        stack_img[depth_now] = VB'(next_num);
        depth_now++;
        next_num++;
      end
    end
    if (last) begin
      verdict_q.push_back(!seq_broken && depth_now == 0);
      depth_now  = 0;
      next_num   = 1;
      seq_broken = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one word per handshake; a new word is presented only once the
  // current one is taken, so tvalid never drops while a word is pending.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : drv
    int unsigned gap;
    pop_word_t   w;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pop_and_judge(s_axis_tdata[VB-1:0], s_axis_tlast);
        words_acc++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap > 0) begin
          gap--;
          s_axis_tvalid <= 1'b0;
        end else if (word_q.size() > 0) begin
          w = word_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= DW'(w.value);
          s_axis_tlast  <= w.last;
          if (idle_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 17);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end else begin
      gap = 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each verdict word against the oldest prediction and
  // stalls tready in random bursts.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : mon
    int unsigned stall;
    bit          want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        verdicts_seen++;
        if (verdict_q.size() == 0) begin
          $error("sequence_valid: expected none, actual %0d", m_axis_tdata[0]);
          err_cnt++;
        end else begin
          want = verdict_q.pop_front();
          if (m_axis_tdata[0] !== want) begin
            $error("sequence_valid: expected %0d, actual %0d", want, m_axis_tdata[0]);
            err_cnt++;
          end
          if (want) passes_seen++;
        end
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 17);
      end
    end else begin
      stall = 0;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_word(input int unsigned v, input bit last);
    pop_word_t w;
    w.value = VB'(v);
    w.last  = last;
    word_q.push_back(w);
    words_queued++;
  endtask

  // Only called with no words in flight and no verdict pending.
  task automatic set_capacity(input logic [CAP_W-1:0] c);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= c;
    cap_now = c;
    cap_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every word is taken and every verdict checked, then let the
  // block settle.
  task automatic drain();
    while (words_acc != words_queued || verdict_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // A pop order built from a random push/pop walk over 1..n, optionally
  // damaged: swapped pair, replaced value (zero possible), dropped tail,
  // or a repeated value.
  task automatic add_perm(input bit wide, input bit broken);
    int unsigned n, pushed, i, j, tmp;
    int unsigned held[$];
    int unsigned order[$];
    n = (wide && $urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 10);
    pushed = 0;
    while (order.size() < n) begin
      if (pushed < n && (held.size() == 0 || $urandom_range(0, 1) == 1)) begin
        pushed++;
        held.push_back(pushed);
      end else begin
        order.push_back(held.pop_back());
      end
    end
    if (broken) begin
      i = $urandom_range(0, n - 1);
      j = $urandom_range(0, n - 1);
      case ($urandom_range(0, 3))
        0: begin
          tmp      = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        1: order[i] = $urandom_range(0, n + 2);
        2: if (n > 1) void'(order.pop_back());
        default: order.insert(i, order[j]);
      endcase
    end
    foreach (order[k]) queue_word(order[k], k == order.size() - 1);
  endtask

  // Arbitrary values with scattered tlast; full 10-bit range, kept mostly
  // small when the capacity is large so push runs stay short.
  task automatic add_noise(input bit wide);
    int unsigned   len;
    logic [VB-1:0] v;
    len = $urandom_range(1, 6);
    for (int k = 0; k < len; k++) begin
      if (!wide || $urandom_range(0, 15) == 0) v = VB'($urandom());
      else v = VB'($urandom_range(0, 40));
      queue_word(v, k == len - 1 || $urandom_range(0, 5) == 0);
    end
  endtask

  task automatic fill_phase(input int unsigned cnt, input bit wide);
    int unsigned goal;
    goal = words_queued + cnt;
    while (words_queued < goal) begin
      case ($urandom_range(0, 9))
        0, 1:    add_noise(wide);
        2, 3:    add_perm(wide, 1'b1);
        default: add_perm(wide, 1'b0);
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [CAP_W-1:0] c;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset capacity of 5
    queue_word(1, 1);                                         // trivial pass
    queue_word(0, 1);                                         // zero never stored
    queue_word(3, 0); queue_word(2, 0); queue_word(1, 1);     // reverse, fits
    queue_word(6, 1);                                         // overflows 5 entries
    queue_word(3, 0); queue_word(1, 0); queue_word(2, 1);     // 1 already passed
    queue_word(2, 1);                                         // leaves 1 on stack
    queue_word(2, 0); queue_word(1, 1);
    queue_word(1023, 0); queue_word(512, 1);                  // fail, then skipped
    drain();

    // Zero capacity: first push fails
    set_capacity(0);
    queue_word(1, 1);
    drain();

    // Capacity above depth saturates; 1023 pushes then a non-empty stack
    set_capacity(2047);
    queue_word(1023, 1);
    queue_word(5, 0); queue_word(4, 0); queue_word(3, 0); queue_word(2, 0);
    queue_word(1, 1);
    drain();

    // One entry only: in-order passes, 2 then 1 needs two entries
    set_capacity(1);
    queue_word(1, 0); queue_word(2, 0); queue_word(3, 1);
    queue_word(2, 0); queue_word(1, 1);
    drain();

    // Random phases across capacities, extremes included; last one calm
    for (int p = 0; p < 10; p++) begin
      case (p)
        0:       c = 3;
        1:       c = 1;
        2:       c = 2047;
        3:       c = 2;
        4:       c = 1024;
        5:       c = CAP_W'($urandom_range(4, 16));
        6:       c = 0;
        7:       c = CAP_W'($urandom_range(0, 2047));
        8:       c = CAP_W'($urandom_range(1, 8));
        default: c = 4;
      endcase
      if (p == 9) idle_on = 1'b0;
      set_capacity(c);
      fill_phase(80, c > 64);
      drain();
    end

    $display("tb: %0d words over %0d capacity settings (0, 1, 1024, 2047 among them)",
             words_acc, cap_writes + 1);
    $display("tb: %0d verdicts checked, %0d legal pop orders", verdicts_seen, passes_seen);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
